[rtl/core/gf_mvm_pkg.sv]
// ----------------------------------------------------------------------------
// gf_mvm_pkg
// Shared types, register indexes, reset values and the GF(2^8) doubling
// helper for the GF(2^8) matrix-vector multiplier.
// ----------------------------------------------------------------------------
package gf_mvm_pkg;

  // Vector geometry
  localparam int unsigned NumElems = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NumPows  = 8;
  localparam int unsigned VecW     = NumElems * ByteW;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_COL0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COL1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COL2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COL3 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_POLY = 3'd4;

  // Reset values: AES MixColumns matrix and the AES polynomial
  localparam logic [VecW-1:0]  COL0_RST = 32'h0301_0102;
  localparam logic [VecW-1:0]  COL1_RST = 32'h0101_0203;
  localparam logic [VecW-1:0]  COL2_RST = 32'h0102_0301;
  localparam logic [VecW-1:0]  COL3_RST = 32'h0203_0101;
  localparam logic [ByteW-1:0] POLY_RST = 8'h1B;

  typedef logic [ByteW-1:0] byte_t;

  // Column j, byte i is the coefficient in row i
  typedef struct packed {
    logic [NumElems-1:0][VecW-1:0] col;
    byte_t                         poly;
  } cfg_t;

  // pow[j][k] = x_j * 2^k reduced
  typedef logic [NumElems-1:0][NumPows-1:0][ByteW-1:0] pow_arr_t;
  typedef logic [NumElems-1:0][ByteW-1:0]              vec_t;

  // Multiply by x modulo x^8 + poly
  function automatic byte_t xtime(input byte_t b, input byte_t poly);
    return {b[ByteW-2:0], 1'b0} ^ (b[ByteW-1] ? poly : '0);
  endfunction

endpackage

[rtl/core/gf_mvm_cfg.sv]
// ----------------------------------------------------------------------------
// gf_mvm_cfg
// Configuration register file: four matrix columns and the reduction
// polynomial byte. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module gf_mvm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gf_mvm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gf_mvm_pkg::VecW-1:0]    cfg_data_i,
  output gf_mvm_pkg::cfg_t               cfg_o
);
  import gf_mvm_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always able to take a write request
  assign cfg_ready_o = 1'b1;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COL0: cfg_d.col[0] = cfg_data_i;
        REG_COL1: cfg_d.col[1] = cfg_data_i;
        REG_COL2: cfg_d.col[2] = cfg_data_i;
        REG_COL3: cfg_d.col[3] = cfg_data_i;
        REG_POLY: cfg_d.poly   = cfg_data_i[ByteW-1:0];
        default:  cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col[0] <= COL0_RST;
      cfg_q.col[1] <= COL1_RST;
      cfg_q.col[2] <= COL2_RST;
      cfg_q.col[3] <= COL3_RST;
      cfg_q.poly   <= POLY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/gf_mvm_pow_stage.sv]
// ----------------------------------------------------------------------------
// gf_mvm_pow_stage
// Elastic pipeline stage that fills four powers of the per-element power table,
// starting at power BASE. Lower powers pass through and higher ones are cleared.
// ----------------------------------------------------------------------------
module gf_mvm_pow_stage #(
  parameter int BASE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gf_mvm_pkg::byte_t    poly_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  gf_mvm_pkg::pow_arr_t pow_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output gf_mvm_pkg::pow_arr_t pow_o
);
  import gf_mvm_pkg::*;

  localparam int PrevPow = (BASE == 0) ? 0 : BASE - 1;

  logic     valid_q;
  pow_arr_t pow_q, pow_d;

  // Doubling chain, four powers per element
  always_comb begin
    byte_t run;
    for (int j = 0; j < NumElems; j++) begin
      run = (BASE == 0) ? pow_i[j][0] : xtime(pow_i[j][PrevPow], poly_i);
      for (int k = 0; k < NumPows; k++) begin
        if (k < BASE) begin
          pow_d[j][k] = pow_i[j][k];
        end else if (k < BASE + 4) begin
          pow_d[j][k] = run;
          run         = xtime(run, poly_i);
        end else begin
          pow_d[j][k] = '0;
        end
      end
    end
  end

  // Stage moves when empty or when downstream takes the request
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pow_q <= pow_d;
    end
  end

  assign valid_o = valid_q;
  assign pow_o   = pow_q;

endmodule

[rtl/core/gf_mvm_accum.sv]
// ----------------------------------------------------------------------------
// gf_mvm_accum
// Final elastic stage: selects powers by the coefficient bits and XORs all
// products of each row into one output byte. Doubles as the output register.
// ----------------------------------------------------------------------------
module gf_mvm_accum #(
  parameter int DIM = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gf_mvm_pkg::cfg_t     cfg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  gf_mvm_pkg::pow_arr_t pow_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output gf_mvm_pkg::vec_t     vec_o
);
  import gf_mvm_pkg::*;

  logic valid_q;
  vec_t vec_q, vec_d;

  // Row sums; rows and columns past DIM contribute nothing
  always_comb begin
    byte_t sum;
    byte_t coef;
    for (int i = 0; i < NumElems; i++) begin
      sum = '0;
      for (int j = 0; j < NumElems; j++) begin
        coef = cfg_i.col[j][ByteW*i +: ByteW];
        if (i < DIM && j < DIM) begin
          for (int k = 0; k < NumPows; k++) begin
            sum = sum ^ (pow_i[j][k] & {ByteW{coef[k]}});
          end
        end
      end
      vec_d[i] = sum;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

[rtl/core/gf256_matrix_vector_multiply.sv]
// ----------------------------------------------------------------------------
// gf256_matrix_vector_multiply
// Multiplies a column of up to four bytes by a configured square byte matrix
// over GF(2^8), reduced modulo x^8 + a configured low polynomial byte.
//
//   channel  direction  handshake                  payload
//   s_axis   in         s_axis_tvalid/tready       tdata[31:0] vec_in_0..3
//   m_axis   out        m_axis_tvalid/tready       tdata[31:0] vec_out_0..3
//   cfg      in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One column per clock while the output is not stalled, through three register
// stages: powers 0-3, powers 4-7, then select-and-XOR into the output register.
// Each stage holds its request under stall and refills when its successor
// frees up, so bubbles are squeezed out and nothing is dropped or repeated.
// Reset clears the stage valids and loads the AES MixColumns matrix and 0x1B.
// ----------------------------------------------------------------------------
module gf256_matrix_vector_multiply #(
  parameter int DIM = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input column
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [gf_mvm_pkg::VecW-1:0]    s_axis_tdata,  // vec_in_0..vec_in_3, low up
  // Result column
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gf_mvm_pkg::VecW-1:0]    m_axis_tdata,  // vec_out_0..vec_out_3, low up
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gf_mvm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gf_mvm_pkg::VecW-1:0]    cfg_data_i
);
  import gf_mvm_pkg::*;

  cfg_t     cfg;
  pow_arr_t pow_in, pow_lo, pow_hi;
  logic     lo_valid, lo_ready, hi_valid, hi_ready;
  vec_t     vec_out;

  gf_mvm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Seed power zero with the input bytes
  always_comb begin
    pow_in = '0;
    for (int j = 0; j < NumElems; j++) begin
      pow_in[j][0] = s_axis_tdata[ByteW*j +: ByteW];
    end
  end

  gf_mvm_pow_stage #(.BASE(0)) u_pow_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .poly_i  (cfg.poly),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pow_i   (pow_in),
    .valid_o (lo_valid),
    .ready_i (lo_ready),
    .pow_o   (pow_lo)
  );

  gf_mvm_pow_stage #(.BASE(4)) u_pow_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .poly_i  (cfg.poly),
    .valid_i (lo_valid),
    .ready_o (lo_ready),
    .pow_i   (pow_lo),
    .valid_o (hi_valid),
    .ready_i (hi_ready),
    .pow_o   (pow_hi)
  );

  gf_mvm_accum #(.DIM(DIM)) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (hi_valid),
    .ready_o (hi_ready),
    .pow_i   (pow_hi),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .vec_o   (vec_out)
  );

  assign m_axis_tdata = vec_out;

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the GF(2^8) matrix-vector multiplier. Columns go in
// on the input stream and the results are checked against a local GF(2^8)
// matrix product that tracks every configuration write. Two passes pace both
// stream sides at random and a third runs without stalls, each with a range
// of matrices and reduction polynomials: AES, all-zero, all-ones, identity,
// inverse MixColumns and random ones.
// ----------------------------------------------------------------------------
module testbench;
  import gf_mvm_pkg::*;

  localparam int          MatDim       = 4;
  localparam int          ItemsPerStep = 65;
  localparam int          NumSettings  = 10;
  localparam int unsigned CycleLimit   = 400000;
  localparam int          MaxPrinted   = 100;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [VecW-1:0]     s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [VecW-1:0]     m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [VecW-1:0]     cfg_data_i    = '0;

  // Shadow of the block's registers
  logic [NumElems-1:0][VecW-1:0] col_shadow = {COL3_RST, COL2_RST, COL1_RST, COL0_RST};
  byte_t                         poly_shadow = POLY_RST;

  // Columns waiting to be sent, and products waiting to come back
  logic [VecW-1:0] pending_columns[$];
  vec_t            expected_columns[$];

  int unsigned cycle_count    = 0;
  int unsigned issued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned results_seen   = 0;
  int unsigned error_count    = 0;
  int unsigned settings_done  = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  logic        driving_on     = 1'b0;
  logic        in_taken       = 1'b0;
  logic        cfg_taken      = 1'b0;

  gf256_matrix_vector_multiply #(
    .DIM(MatDim)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // vec_in_0..vec_in_3, low up
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // vec_out_0..vec_out_3, low up
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Carry-less multiply with shift-and-XOR reduction by x^8 + poly
  function automatic byte_t gf_product(input byte_t a, input byte_t b, input byte_t poly);
    byte_t acc;
    byte_t sh;
    acc = '0;
    sh  = b;
    for (int k = 0; k < ByteW; k++) begin
      if (a[k]) acc ^= sh;
      sh = sh[7] ? ({sh[6:0], 1'b0} ^ poly) : {sh[6:0], 1'b0};
    end
    return acc;
  endfunction

  // Row i of the result: XOR over the columns in use; rows past the size stay zero
  function automatic vec_t mix_column(input vec_t x);
    vec_t y;
    y = '0;
    for (int i = 0; i < MatDim; i++) begin
      for (int j = 0; j < MatDim; j++) begin
        y[i] ^= gf_product(col_shadow[j][8*i +: 8], x[j], poly_shadow);
      end
    end
    return y;
  endfunction

  // Bytes lean toward the corner values now and then
  function automatic byte_t random_byte();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 8'h00;
          1: return 8'hFF;
          2: return 8'h01;
          default: return 8'h80;
        endcase
      end
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [VecW-1:0] random_column();
    return {random_byte(), random_byte(), random_byte(), random_byte()};
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  // Monitor: check results, track config writes, predict accepted columns
  always @(posedge clk_i) begin : monitor
    vec_t got;
    vec_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
    in_taken  <= rst_ni && s_axis_tvalid && s_axis_tready;
    cfg_taken <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        results_seen++;
        if (expected_columns.size() == 0) begin
          report_mismatch($sformatf("unexpected result %08h", m_axis_tdata));
        end else begin
          want = expected_columns.pop_front();
          for (int i = 0; i < NumElems; i++) begin
            if (got[i] !== want[i])
              report_mismatch($sformatf("result %0d vec_out_%0d: got %02h, expected %02h",
                                        results_seen, i, got[i], want[i]));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_COL0: col_shadow[0] = cfg_data_i;
          REG_COL1: col_shadow[1] = cfg_data_i;
          REG_COL2: col_shadow[2] = cfg_data_i;
          REG_COL3: col_shadow[3] = cfg_data_i;
          REG_POLY: poly_shadow   = cfg_data_i[ByteW-1:0];
          default: ;  // out-of-range index is dropped
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        accepted_count++;
        expected_columns.push_back(mix_column(s_axis_tdata));
      end
    end
  end

  // Driver: source side holds its request until taken, sink side stalls at random
  always @(negedge clk_i) begin
    if (driving_on) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_columns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_columns.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_column(input logic [VecW-1:0] col);
    pending_columns.push_back(col);
    issued_count++;
  endtask

  // Wait until every column is in and every result is out, plus pipeline slack
  task automatic wait_idle();
    do @(negedge clk_i);
    while (accepted_count != issued_count || expected_columns.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [VecW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i);
    while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Load one matrix/polynomial setting; block must be idle
  task automatic apply_setting(input int k);
    logic [NumElems-1:0][VecW-1:0] c;
    logic [VecW-1:0]               poly_word;
    case (k)
      0: begin
        c         = {COL3_RST, COL2_RST, COL1_RST, COL0_RST};
        poly_word = {24'h0, POLY_RST};
      end
      1: begin
        c         = '0;
        poly_word = 32'hFFFF_FF00;
      end
      2: begin
        c         = '1;
        poly_word = 32'h0000_00FF;
      end
      3: begin
        c         = {32'h0100_0000, 32'h0001_0000, 32'h0000_0100, 32'h0000_0001};
        poly_word = 32'h0000_001B;
      end
      4: begin
        // inverse MixColumns
        c         = {32'h0E0B_0D09, 32'h090E_0B0D, 32'h0D09_0E0B, 32'h0B0D_090E};
        poly_word = 32'h0000_001B;
      end
      default: begin
        for (int j = 0; j < NumElems; j++) c[j] = random_column();
        poly_word = $urandom;
      end
    endcase
    wait_idle();
    write_register(REG_POLY, poly_word);
    write_register(REG_COL0, c[0]);
    write_register(REG_COL1, c[1]);
    write_register(REG_COL2, c[2]);
    write_register(REG_COL3, c[3]);
    if (k >= 5) write_register(CfgIdxW'($urandom_range(5, 7)), $urandom);
    settings_done++;
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni     <= 1'b1;
    @(negedge clk_i);
    driving_on = 1'b1;
    send_idle_pct = 14;
    recv_idle_pct = 57;

    // Directed columns under the reset (AES) matrix
    send_column(32'h0000_0000);
    send_column(32'hFFFF_FFFF);
    send_column(32'h0000_00FF);
    send_column(32'h0000_FF00);
    send_column(32'h00FF_0000);
    send_column(32'hFF00_0000);
    for (int j = 0; j < NumElems; j++) send_column(32'h01 << (8*j));
    for (int j = 0; j < NumElems; j++) send_column(32'h80 << (8*j));
    send_column(32'h55AA_55AA);
    send_column(32'hAA55_AA55);
    send_column(32'h4553_13DB);
    send_column(32'h5C22_0AF2);
    send_column(32'hD4D4_C6C6);
    wait_idle();

    // Out-of-range register indexes must leave the setup alone
    write_register(3'd5, 32'hFFFF_FFFF);
    write_register(3'd6, 32'h0000_0000);
    write_register(3'd7, 32'hA5A5_A5A5);
    send_column(32'h4553_13DB);
    send_column(32'hFFFF_FFFF);
    settings_done++;

    // Three pacing modes, each over the full list of settings
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 14; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int k = 0; k < NumSettings; k++) begin
        apply_setting(k);
        for (int n = 0; n < ItemsPerStep; n++) send_column(random_column());
      end
    end

    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("Checked %0d result columns across %0d register setups", results_seen, settings_done);
    $display("Pacing: source/sink stalls 14/57, then 57/14, then none");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
